### hdl/bstk_pkg.sv
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types and constants for the bounded stack with search.
// ----------------------------------------------------------------------------
package bstk_pkg;

	localparam int BSTK_DEPTH  = 8;
	localparam int BSTK_DATA_W = 32;

	// request kinds on the slave-side tuser
	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_DISP = 2'd2,
		REQ_SRCH = 2'd3
	} req_t;

	// result status on the master-side tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVFL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_DISP = 4'b0100,
		S_SRCH = 4'b1000
	} fsm_t;

endpackage

### hdl/bounded_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// LIFO stack of signed 32-bit words with pop, full listing and key search.
// ----------------------------------------------------------------------------
// One request word is taken at a time. A push finishes in the cycle it is
// accepted and its result word is ready the next cycle. A pop returns the
// top entry with one RAM read. A listing of N stored words produces N
// result words, top first, one per cycle while the output is not stalled.
// A search walks from the top down, one entry per cycle, and stops at the
// first hit or at the bottom entry. Requests to an empty stack, and a push
// to a full one, finish in the cycle they are accepted. The pop, listing
// and search steps are set by the single read port of the stack RAM and
// its registered read. A new request is taken once the sequencer is idle
// and the output register is empty or being drained.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_core
	import bstk_pkg::*;
#(
	parameter int DEPTH = BSTK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] data, [32] found, [33] is_full,
	                                    // [34] is_empty, [39:35] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	// control state
	fsm_t              state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ADDR_W-1:0] idx_q, idx_d;

	// payload
	logic signed [BSTK_DATA_W-1:0] key_q;

	// output register
	logic                          m_valid_q;
	status_t                       o_status_q;
	logic signed [BSTK_DATA_W-1:0] o_data_q;
	logic                          o_found_q, o_full_q, o_empty_q, o_last_q;

	// RAM port
	logic                    wr_en, rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic [BSTK_DATA_W-1:0]  rd_data;

	// combinational results
	logic                          accept, out_free, key_load, out_load;
	status_t                       o_status;
	logic signed [BSTK_DATA_W-1:0] o_data;
	logic                          o_found, o_last;
	logic                          cnt_empty, cnt_full;
	logic [CNT_W-1:0]              cnt_m1;
	logic [ADDR_W-1:0]             top_idx, idx_m1;
	req_t                          req;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = req_t'(s_axis_tuser);

	assign cnt_empty = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CNT_W'(DEPTH));
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign top_idx   = cnt_m1[ADDR_W-1:0];
	assign idx_m1    = idx_q - ADDR_W'(1);

	// Reads and writes never overlap on one entry: a write lands at its
	// accept edge, and the next request is accepted, and read, only at a later edge.
	bstk_ram #(
		.WIDTH (BSTK_DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (s_axis_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		key_load = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = top_idx;
		out_load = 1'b0;
		o_status = ST_OK;
		o_data   = '0;
		o_found  = 1'b0;
		o_last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req == REQ_PUSH) begin
						out_load = 1'b1;
						if (cnt_full) begin
							o_status = ST_OVFL;
						end else begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CNT_W'(1);
						end
					end else if (cnt_empty) begin
						// pop, listing or search on an empty stack
						out_load = 1'b1;
						o_status = ST_EMPTY;
					end else begin
						// start reading the top entry
						rd_en = 1'b1;
						idx_d = top_idx;
						case (req)
							REQ_POP: begin
								cnt_d   = cnt_m1;
								state_d = S_POP;
							end
							REQ_DISP: state_d = S_DISP;
							default: begin
								key_load = 1'b1;
								state_d  = S_SRCH;
							end
						endcase
					end
				end
			end
			S_POP: begin
				// output register was drained at accept
				out_load = 1'b1;
				o_data   = rd_data;
				state_d  = S_IDLE;
			end
			S_DISP: begin
				// hold the read word while the output stalls
				if (out_free) begin
					out_load = 1'b1;
					o_data   = rd_data;
					o_last   = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_m1;
						idx_d   = idx_m1;
					end
				end
			end
			S_SRCH: begin
				if ((rd_data == key_q) || (idx_q == '0)) begin
					out_load = 1'b1;
					o_found  = (rd_data == key_q);
					state_d  = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_m1;
					idx_d   = idx_m1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers; flags reflect the count after the request
	always_ff @(posedge clk) begin
		if (key_load) begin
			key_q <= s_axis_tdata;
		end
		if (out_load) begin
			o_status_q <= o_status;
			o_data_q   <= o_data;
			o_found_q  <= o_found;
			o_full_q   <= (cnt_d == CNT_W'(DEPTH));
			o_empty_q  <= (cnt_d == '0);
			o_last_q   <= o_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = o_status_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {5'b0, o_empty_q, o_full_q, o_found_q, o_data_q};

endmodule

### hdl/bstk_ram.sv
// ----------------------------------------------------------------------------
// bstk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bstk_ram
	import bstk_pkg::*;
#(
	parameter int WIDTH = BSTK_DATA_W,
	parameter int DEPTH = BSTK_DEPTH,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### tb/sv/bounded_stack_with_search_core_tb.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core_tb
// Self-checking bench for the bounded stack: directed empty, full, listing,
// search and drain cases, then random request mixes under three idle
// patterns, each result word checked against a shadow stack.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_core_tb;
	import bstk_pkg::*;

	localparam int STK_DEPTH   = BSTK_DEPTH;
	localparam int CYCLE_LIMIT = 400_000;

	typedef struct {
		status_t     status;
		logic [31:0] data;
		logic        found;
		logic        full;
		logic        empty;
		logic        last;
	} stack_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] value
	logic [1:0]  s_axis_tuser;   // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] data, [32] found, [33] is_full, [34] is_empty
	logic [1:0]  m_axis_tuser;   // [1:0] status
	logic        m_axis_tlast;

	// shadow copy of the stack contents
	logic [31:0]   shadow_words [STK_DEPTH];
	int            shadow_count;
	stack_result_t pending_results [$];

	int src_idle_pct;
	int dst_idle_pct;
	int mismatch_count;
	int cycle_count;

	bounded_stack_with_search_core #(
		.DEPTH(STK_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// flags always reflect the stack as it stands after the request
	function automatic stack_result_t make_result(status_t st, logic [31:0] d, logic f,
		logic lst);
		stack_result_t r;
		r.status = st;
		r.data   = d;
		r.found  = f;
		r.full   = (shadow_count >= STK_DEPTH);
		r.empty  = (shadow_count == 0);
		r.last   = lst;
		return r;
	endfunction

	// update the shadow stack and queue the result words one request causes
	task automatic apply_request(input req_t kind, input logic [31:0] val);
		int   i;
		logic hit;
		if (kind == REQ_PUSH) begin
			if (shadow_count >= STK_DEPTH) begin
				pending_results.push_back(make_result(ST_OVFL, '0, 1'b0, 1'b1));
			end else begin
				shadow_words[shadow_count] = val;
				shadow_count++;
				pending_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
			end
		end else if (shadow_count == 0) begin
			pending_results.push_back(make_result(ST_EMPTY, '0, 1'b0, 1'b1));
		end else begin
			case (kind)
				REQ_POP: begin
					shadow_count--;
					pending_results.push_back(make_result(ST_OK, shadow_words[shadow_count],
						1'b0, 1'b1));
				end
				REQ_DISP: begin
					// top first, only the bottom word closes the listing
					for (i = shadow_count - 1; i >= 0; i--)
						pending_results.push_back(make_result(ST_OK, shadow_words[i], 1'b0,
							i == 0));
				end
				default: begin
					hit = 1'b0;
					for (i = shadow_count - 1; i >= 0; i--)
						if (shadow_words[i] == val)
							hit = 1'b1;
					pending_results.push_back(make_result(ST_OK, '0, hit, 1'b1));
				end
			endcase
		end
	endtask

	// enter at a falling edge, return at the falling edge after acceptance
	task automatic send_request(input req_t kind, input logic [31:0] val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= val;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		apply_request(kind, val);
		@(negedge clk);
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// receiver: stall at random on the falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);

	// check every accepted result word against the oldest expectation
	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result word, expected none, actual %h tuser %h",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_results.pop_front();
				report_field("status", 32'(want.status), 32'(m_axis_tuser));
				report_field("data", want.data, m_axis_tdata[31:0]);
				report_field("found", 32'(want.found), 32'(m_axis_tdata[32]));
				report_field("is_full", 32'(want.full), 32'(m_axis_tdata[33]));
				report_field("is_empty", 32'(want.empty), 32'(m_axis_tdata[34]));
				report_field("pad", 32'd0, 32'(m_axis_tdata[39:35]));
				report_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_stack_with_search_core regression: fail");
			$finish;
		end
	end

	// mostly extremes and small values so searches hit now and then
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_stack();
		send_request(REQ_POP, 32'h1234_5678);
		send_request(REQ_DISP, 32'hffff_ffff);
		send_request(REQ_SRCH, 32'h0000_0000);
	endtask

	// bottom word is unique so a deep search hit is exercised
	task automatic test_fill_overflow();
		logic [31:0] fill_vals [8];
		int          i;
		fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'h1234_5678};
		for (i = 0; i < STK_DEPTH; i++)
			send_request(REQ_PUSH, (i == STK_DEPTH - 1) ? 32'h1234_5678 :
				(i == 0) ? 32'h8000_0000 : fill_vals[1 + (i - 1) % 6]);
		send_request(REQ_PUSH, 32'h7fff_ffff);
	endtask

	task automatic test_list_and_search();
		send_request(REQ_DISP, 32'h0000_0000);
		send_request(REQ_SRCH, 32'h8000_0000);
		send_request(REQ_SRCH, 32'h1234_5678);
		send_request(REQ_SRCH, 32'hdead_beef);
	endtask

	task automatic test_drain();
		int i;
		for (i = 0; i < STK_DEPTH; i++)
			send_request(REQ_POP, $urandom);
		send_request(REQ_POP, $urandom);
	endtask

	// alternate fill-heavy and drain-heavy stretches so both ends get visited
	task automatic test_random_mix(input int n_items);
		int          k;
		int          push_pct;
		logic [31:0] key;
		for (k = 0; k < n_items; k++) begin
			push_pct = ((k / 16) % 2 == 0) ? 60 : 25;
			if ($urandom_range(0, 99) < push_pct) begin
				send_request(REQ_PUSH, pick_value());
			end else begin
				case ($urandom_range(0, 3))
					0, 1: send_request(REQ_POP, $urandom);
					2: send_request(REQ_DISP, $urandom);
					default: begin
						if (shadow_count > 0 && $urandom_range(0, 1) == 1)
							key = shadow_words[$urandom_range(0, shadow_count - 1)];
						else
							key = pick_value();
						send_request(REQ_SRCH, key);
					end
				endcase
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = REQ_PUSH;
		m_axis_tready  = 1'b0;
		shadow_count   = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		src_idle_pct   = 22;
		dst_idle_pct   = 82;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_fill_overflow();
		test_list_and_search();
		test_drain();
		test_random_mix(62);

		src_idle_pct = 82;
		dst_idle_pct = 22;
		test_random_mix(62);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		test_random_mix(62);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray word after the last expected one
		repeat (STK_DEPTH + 4) @(posedge clk);

		if (mismatch_count == 0)
			$display("bounded_stack_with_search_core regression: pass");
		else
			$display("bounded_stack_with_search_core regression: fail");
		$finish;
	end

endmodule
